### hdl/four_voice_pcm_sample_mixer_unit_defines.svh
// assertion macros for the four-voice sample mixer checker
// no dependencies; included by the checker file only
`ifndef FOUR_VOICE_PCM_SAMPLE_MIXER_UNIT_DEFINES_SVH
`define FOUR_VOICE_PCM_SAMPLE_MIXER_UNIT_DEFINES_SVH

// next-cycle implication, disabled while reset is asserted
`define FVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fvm checker: property failed");

// next-cycle implication that also holds through reset
`define FVM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fvm checker: property failed");

`endif

### hdl/fvm_pkg.sv
// shared types and constants of the four-voice sample mixer
// no dependencies; used by the top level, fvm_mix_out, the checker and the testbench
package fvm_pkg;

    localparam int STORE_WORDS = 65536;
    localparam int STORE_AW    = $clog2(STORE_WORDS);
    localparam int VOICE_COUNT = 4;
    localparam int VOICE_IW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [VOICE_IW-1:0] VOICE_LAST = VOICE_IW'(VOICE_COUNT - 1);

    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 16;
    localparam int VSEL_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 18;
    localparam int MIX_SHIFT  = 2;
    localparam int LEVEL_W    = 16;
    localparam int BYTE_W     = 8;
    localparam logic [SUM_W-1:0] MIX_CENTRE = SUM_W'(131072);

    localparam int OUT_DEPTH = 2;
    localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_ACTIVATE = 2'd1,
        FUNC_STORE    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } seq_state_t;

    typedef struct packed {
        func_t                       func;
        logic [VSEL_W-1:0]           voice_select;
        logic                        turn_on;
        logic [ADDR_W-1:0]           store_address;
        logic signed [SAMPLE_W-1:0]  store_value;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] level_high_byte;
        logic [BYTE_W-1:0] level_low_byte;
    } out_item_t;

    // travels with each store read to the mix stage
    typedef struct packed {
        logic vld;
        logic act;
        logic first;
        logic last;
    } mix_tag_t;

endpackage

### hdl/four_voice_pcm_sample_mixer_unit.sv
// top level of the four-voice pcm sample mixer
// depends on fvm_pkg, fvm_ram and fvm_mix_out
//
// A tick walks all VOICE_COUNT voices (4 here) one per cycle on the single
// port of the sample store, so the input is not ready again until the walk
// ends; activate and store-write transfers leave it ready. The level of a
// tick is summed from registered reads, then queued. At most two ticks may be
// walking or waiting in the two-entry result queue at once, so with two
// levels unread the input stalls until the sink takes one. Sample addresses
// wrap modulo STORE_WORDS, which is a power of two. Store words read before
// they are written give undefined levels; there is no clearing pass after
// reset.
module four_voice_pcm_sample_mixer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fvm_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fvm_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [fvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fvm_pkg::seq_state_t             state_reg, state_next;
    logic [fvm_pkg::VOICE_IW-1:0]    vidx_reg, vidx_next;
    logic [fvm_pkg::PEND_W-1:0]      pend_reg, pend_next;

    logic [fvm_pkg::ADDR_W-1:0]      base_reg [fvm_pkg::VOICE_COUNT];
    logic [fvm_pkg::ADDR_W-1:0]      len_reg  [fvm_pkg::VOICE_COUNT];
    logic [fvm_pkg::ADDR_W-1:0]      pos_reg  [fvm_pkg::VOICE_COUNT];
    logic [fvm_pkg::ADDR_W-1:0]      pos_next [fvm_pkg::VOICE_COUNT];
    logic                            on_reg   [fvm_pkg::VOICE_COUNT];
    logic                            on_next  [fvm_pkg::VOICE_COUNT];

    logic                            accept, is_tick, is_act, is_store, walk, issue;
    logic [fvm_pkg::VOICE_IW-1:0]    cur_v;
    logic                            cur_act, last_v;
    logic [fvm_pkg::ADDR_W-1:0]      rd_sum;
    logic                            act_hit, cfg_hit;
    logic [fvm_pkg::VOICE_IW-1:0]    act_v, cfg_v;
    logic [fvm_pkg::VSEL_W-1:0]      cfg_voice;

    logic                            ram_en, ram_we;
    logic [fvm_pkg::STORE_AW-1:0]    ram_addr;
    logic [fvm_pkg::SAMPLE_W-1:0]    ram_rdata;
    fvm_pkg::mix_tag_t               tag;

    assign s_ready = (state_reg == fvm_pkg::ST_IDLE)
                  && (pend_reg != fvm_pkg::PEND_W'(fvm_pkg::OUT_DEPTH));
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_tick  = 1'b0;
        is_act   = 1'b0;
        is_store = 1'b0;
        case (s_data.func)
            fvm_pkg::FUNC_TICK:     is_tick  = accept;
            fvm_pkg::FUNC_ACTIVATE: is_act   = accept;
            fvm_pkg::FUNC_STORE:    is_store = accept;
            default: begin
            end
        endcase
    end

    always_comb begin
        walk    = (state_reg == fvm_pkg::ST_WALK);
        issue   = is_tick || walk;
        cur_v   = walk ? vidx_reg : '0;
        last_v  = (cur_v == fvm_pkg::VOICE_LAST);
        cur_act = on_reg[cur_v] && (pos_reg[cur_v] < len_reg[cur_v]);
        rd_sum  = base_reg[cur_v] + pos_reg[cur_v];

        ram_en   = issue || is_store;
        ram_we   = is_store;
        ram_addr = is_store ? s_data.store_address[fvm_pkg::STORE_AW-1:0]
                            : rd_sum[fvm_pkg::STORE_AW-1:0];

        tag.vld   = issue;
        tag.act   = issue && cur_act;
        tag.first = (cur_v == '0);
        tag.last  = last_v;
    end

    always_comb begin
        state_next = state_reg;
        vidx_next  = vidx_reg;
        case (state_reg)
            fvm_pkg::ST_IDLE: begin
                if (is_tick && !last_v) begin
                    state_next = fvm_pkg::ST_WALK;
                    vidx_next  = cur_v + 1'b1;
                end
            end
            fvm_pkg::ST_WALK: begin
                if (last_v) begin
                    state_next = fvm_pkg::ST_IDLE;
                end else begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            default: begin
                state_next = fvm_pkg::ST_IDLE;
            end
        endcase
        pend_next = pend_reg + fvm_pkg::PEND_W'(is_tick)
                  - fvm_pkg::PEND_W'(m_valid && m_ready);
    end

    // voice advance on reads and restarts from activates and register writes
    always_comb begin
        act_hit   = is_act && ({1'b0, s_data.voice_select}
                                < (fvm_pkg::VSEL_W + 1)'(fvm_pkg::VOICE_COUNT));
        act_v     = s_data.voice_select[fvm_pkg::VOICE_IW-1:0];
        cfg_voice = cfg_index[fvm_pkg::CFG_IDX_W-1:1];
        cfg_hit   = cfg_wr_en && ({1'b0, cfg_voice}
                                  < (fvm_pkg::VSEL_W + 1)'(fvm_pkg::VOICE_COUNT));
        cfg_v     = cfg_voice[fvm_pkg::VOICE_IW-1:0];
        for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++) begin
            pos_next[v] = pos_reg[v];
            on_next[v]  = on_reg[v];
            if (issue && cur_act && (cur_v == fvm_pkg::VOICE_IW'(v))) begin
                pos_next[v] = pos_reg[v] + 1'b1;
            end
            if (act_hit && (act_v == fvm_pkg::VOICE_IW'(v))) begin
                pos_next[v] = '0;
                on_next[v]  = s_data.turn_on;
            end
            if (cfg_hit && (cfg_v == fvm_pkg::VOICE_IW'(v))) begin
                pos_next[v] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fvm_pkg::ST_IDLE;
            vidx_reg  <= '0;
            pend_reg  <= '0;
            for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++) begin
                base_reg[v] <= '0;
                len_reg[v]  <= '0;
                pos_reg[v]  <= '0;
                on_reg[v]   <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
            pend_reg  <= pend_next;
            for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++) begin
                pos_reg[v] <= pos_next[v];
                on_reg[v]  <= on_next[v];
                if (cfg_hit && (cfg_v == fvm_pkg::VOICE_IW'(v))) begin
                    if (cfg_index[0]) begin
                        len_reg[v] <= cfg_data;
                    end else begin
                        base_reg[v] <= cfg_data;
                    end
                end
            end
        end
    end

    fvm_ram #(
        .WIDTH (fvm_pkg::SAMPLE_W),
        .DEPTH (fvm_pkg::STORE_WORDS)
    ) u_store (
        .clk   (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data.store_value),
        .rdata (ram_rdata)
    );

    fvm_mix_out u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (tag),
        .rdata   (ram_rdata),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### hdl/fvm_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module fvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

### hdl/fvm_mix_out.sv
// mix accumulator and two-entry result queue
// depends on fvm_pkg
module fvm_mix_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fvm_pkg::mix_tag_t             tag_in,
    input  logic [fvm_pkg::SAMPLE_W-1:0]  rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fvm_pkg::out_item_t            m_data
);

    fvm_pkg::mix_tag_t            tag_reg;
    logic [fvm_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [fvm_pkg::SUM_W-1:0]    acc;
    logic [fvm_pkg::LEVEL_W-1:0]  level;
    fvm_pkg::out_item_t           q_reg [fvm_pkg::OUT_DEPTH];
    logic                         wr_ptr_reg, rd_ptr_reg;
    logic [fvm_pkg::PEND_W-1:0]   cnt_reg, cnt_next;
    logic                         push, pop;

    always_comb begin
        acc = (tag_reg.first ? fvm_pkg::MIX_CENTRE : sum_reg)
            + (tag_reg.act ? {{(fvm_pkg::SUM_W - fvm_pkg::SAMPLE_W){rdata[fvm_pkg::SAMPLE_W-1]}},
                              rdata}
                           : '0);
        level    = acc[fvm_pkg::MIX_SHIFT +: fvm_pkg::LEVEL_W];
        sum_next = tag_reg.vld ? acc : sum_reg;
        push     = tag_reg.vld && tag_reg.last;
        pop      = m_valid && m_ready;
        cnt_next = cnt_reg + fvm_pkg::PEND_W'(push) - fvm_pkg::PEND_W'(pop);
    end

    assign m_valid = (cnt_reg != '0);
    assign m_data  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            tag_reg <= tag_in;
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (push) begin
            q_reg[wr_ptr_reg] <= {level[fvm_pkg::LEVEL_W-1 -: fvm_pkg::BYTE_W],
                                  level[fvm_pkg::BYTE_W-1:0]};
        end
    end

endmodule

### hdl/fvm_checker.sv
// port-level checker for the four-voice sample mixer, bound to the top level
// depends on fvm_pkg and the defines header
`include "four_voice_pcm_sample_mixer_unit_defines.svh"

module fvm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input fvm_pkg::in_item_t               s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input fvm_pkg::out_item_t              m_data,
    input logic                            cfg_wr_en,
    input logic [fvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [fvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic tick_xfer, other_xfer;

    assign tick_xfer  = s_valid && s_ready && (s_data.func == fvm_pkg::FUNC_TICK);
    assign other_xfer = s_valid && s_ready && (s_data.func != fvm_pkg::FUNC_TICK);

    `FVM_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `FVM_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)
    `FVM_ASSERT_NEXT(a_tick_walk, aclk, aresetn, tick_xfer && (fvm_pkg::VOICE_COUNT > 1), !s_ready)
    `FVM_ASSERT_NEXT(a_single_cycle, aclk, aresetn, other_xfer, s_ready)

endmodule

bind four_voice_pcm_sample_mixer_unit fvm_checker u_fvm_checker (.*);

### test/tb.sv
// testbench for four_voice_pcm_sample_mixer_unit: random and directed transfers with
// idling on both sides, levels checked against a built-in mixing predictor
// depends on fvm_pkg and the mixer rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int REGS_PER_VOICE = 2;
    localparam int REG_BASE_OFS = 0;
    localparam int REG_LEN_OFS = 1;
    localparam logic [fvm_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [fvm_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    fvm_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    fvm_pkg::out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [fvm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fvm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    four_voice_pcm_sample_mixer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic signed [fvm_pkg::SAMPLE_W-1:0] store_copy [fvm_pkg::STORE_WORDS];
    logic [fvm_pkg::ADDR_W-1:0] mix_base [fvm_pkg::VOICE_COUNT] = '{default: '0};
    logic [fvm_pkg::ADDR_W-1:0] mix_len [fvm_pkg::VOICE_COUNT] = '{default: '0};
    logic [fvm_pkg::ADDR_W-1:0] mix_pos [fvm_pkg::VOICE_COUNT] = '{default: '0};
    logic mix_on [fvm_pkg::VOICE_COUNT] = '{default: 1'b0};
    fvm_pkg::out_item_t levels_due [$];

    // stimulus-side view, kept only so no unwritten word is ever played
    logic [fvm_pkg::ADDR_W-1:0] gen_base [fvm_pkg::VOICE_COUNT] = '{default: '0};
    logic [fvm_pkg::ADDR_W-1:0] gen_len [fvm_pkg::VOICE_COUNT] = '{default: '0};
    logic [fvm_pkg::ADDR_W-1:0] gen_pos [fvm_pkg::VOICE_COUNT] = '{default: '0};
    logic gen_on [fvm_pkg::VOICE_COUNT] = '{default: 1'b0};
    bit gen_written [fvm_pkg::STORE_WORDS];
    fvm_pkg::in_item_t items_to_send [$];

    int err_count = 0;
    int levels_checked = 0;
    int items_in = 0;
    int gen_count = 0;
    int settings_done = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    bit in_xfer = 1'b0;
    int src_gap = 0;
    int snk_stall = 0;

    function automatic void mix_predict(input fvm_pkg::in_item_t it);
        int sum;
        logic [fvm_pkg::ADDR_W-1:0] a;
        logic [fvm_pkg::LEVEL_W-1:0] level;
        fvm_pkg::out_item_t lvl;
        case (it.func)
            fvm_pkg::FUNC_ACTIVATE: begin
                if (int'(it.voice_select) < fvm_pkg::VOICE_COUNT) begin
                    mix_on[it.voice_select] = it.turn_on;
                    mix_pos[it.voice_select] = '0;
                end
            end
            fvm_pkg::FUNC_STORE: begin
                store_copy[int'(it.store_address) % fvm_pkg::STORE_WORDS] = it.store_value;
            end
            fvm_pkg::FUNC_TICK: begin
                sum = int'(fvm_pkg::MIX_CENTRE);
                for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++) begin
                    if (mix_on[v] && mix_pos[v] < mix_len[v]) begin
                        a = mix_base[v] + mix_pos[v];
                        sum += int'(store_copy[int'(a) % fvm_pkg::STORE_WORDS]);
                        mix_pos[v] = mix_pos[v] + 1'b1;
                    end
                end
                level = fvm_pkg::LEVEL_W'(sum >> fvm_pkg::MIX_SHIFT);
                lvl.level_high_byte = level[fvm_pkg::LEVEL_W-1 -: fvm_pkg::BYTE_W];
                lvl.level_low_byte = level[fvm_pkg::BYTE_W-1:0];
                levels_due.push_back(lvl);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("tb: mismatch in %s after %0d levels: got %0h, want %0h",
                     what, levels_checked, got, want);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 30);
    endfunction

    function automatic logic [fvm_pkg::SAMPLE_W-1:0] sample_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return SAMPLE_MAX;
        if (r < 30) return SAMPLE_MIN;
        return fvm_pkg::SAMPLE_W'($urandom);
    endfunction

    function automatic fvm_pkg::in_item_t rand_item(input logic [1:0] f);
        fvm_pkg::in_item_t it;
        it.func = fvm_pkg::func_t'(f);
        it.voice_select = fvm_pkg::VSEL_W'($urandom_range(0, 3));
        it.turn_on = 1'($urandom_range(0, 1));
        it.store_address = fvm_pkg::ADDR_W'($urandom);
        it.store_value = sample_pick();
        return it;
    endfunction

    function automatic void gen_push(input fvm_pkg::in_item_t it);
        items_to_send.push_back(it);
        gen_count++;
        case (it.func)
            fvm_pkg::FUNC_ACTIVATE: begin
                if (int'(it.voice_select) < fvm_pkg::VOICE_COUNT) begin
                    gen_on[it.voice_select] = it.turn_on;
                    gen_pos[it.voice_select] = '0;
                end
            end
            fvm_pkg::FUNC_STORE:
                gen_written[int'(it.store_address) % fvm_pkg::STORE_WORDS] = 1'b1;
            fvm_pkg::FUNC_TICK: begin
                for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++)
                    if (gen_on[v] && gen_pos[v] < gen_len[v])
                        gen_pos[v] = gen_pos[v] + 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void push_store(input logic [fvm_pkg::ADDR_W-1:0] a,
                                       input logic [fvm_pkg::SAMPLE_W-1:0] val);
        fvm_pkg::in_item_t it;
        it = rand_item(fvm_pkg::FUNC_STORE);
        it.store_address = a;
        it.store_value = val;
        gen_push(it);
    endfunction

    function automatic void push_activate(input int v, input logic on);
        fvm_pkg::in_item_t it;
        it = rand_item(fvm_pkg::FUNC_ACTIVATE);
        it.voice_select = fvm_pkg::VSEL_W'(v);
        it.turn_on = on;
        gen_push(it);
    endfunction

    // fills any word a playing voice is about to read, then sends the tick
    function automatic void push_tick();
        logic [fvm_pkg::ADDR_W-1:0] a;
        for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++) begin
            if (gen_on[v] && gen_pos[v] < gen_len[v]) begin
                a = gen_base[v] + gen_pos[v];
                if (!gen_written[int'(a) % fvm_pkg::STORE_WORDS])
                    push_store(a, sample_pick());
            end
        end
        gen_push(rand_item(fvm_pkg::FUNC_TICK));
    endfunction

    function automatic void gen_phase(input int n);
        int start;
        int r;
        int v;
        start = gen_count;
        while (gen_count - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_tick();
            end else if (r < 50) begin
                push_activate($urandom_range(0, fvm_pkg::VOICE_COUNT - 1),
                              $urandom_range(0, 3) != 0);
            end else if (r < 95) begin
                v = $urandom_range(0, fvm_pkg::VOICE_COUNT - 1);
                if ($urandom_range(0, 1) == 0)
                    push_store(gen_base[v] + fvm_pkg::ADDR_W'($urandom_range(0, 63)),
                               sample_pick());
                else
                    push_store(fvm_pkg::ADDR_W'($urandom), sample_pick());
            end else begin
                gen_push(rand_item(FUNC_SPARE));
            end
        end
    endfunction

    task automatic write_reg(input int idx, input logic [fvm_pkg::CFG_DATA_W-1:0] val);
        int v;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= fvm_pkg::CFG_IDX_W'(idx);
        cfg_data <= val;
        @(posedge aclk);
        v = idx / REGS_PER_VOICE;
        if (idx % REGS_PER_VOICE == REG_BASE_OFS) begin
            mix_base[v] = val;
            gen_base[v] = val;
        end else begin
            mix_len[v] = val;
            gen_len[v] = val;
        end
        mix_pos[v] = '0;
        gen_pos[v] = '0;
    endtask

    task automatic program_voice(input int v, input logic [fvm_pkg::ADDR_W-1:0] base,
                                 input logic [fvm_pkg::ADDR_W-1:0] len);
        write_reg(v * REGS_PER_VOICE + REG_BASE_OFS, base);
        write_reg(v * REGS_PER_VOICE + REG_LEN_OFS, len);
    endtask

    function automatic logic [fvm_pkg::ADDR_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return '0;
        if (r == 1) return fvm_pkg::ADDR_W'(16'hFFFF - $urandom_range(0, 20));
        if (r == 2) return fvm_pkg::ADDR_W'(16'h4000 + $urandom_range(0, 8));
        return fvm_pkg::ADDR_W'($urandom);
    endfunction

    function automatic logic [fvm_pkg::ADDR_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return fvm_pkg::ADDR_W'(1);
        if (r < 35) return 16'hFFFF;
        if (r < 80) return fvm_pkg::ADDR_W'($urandom_range(2, 48));
        return fvm_pkg::ADDR_W'($urandom);
    endfunction

    task automatic wait_idle();
        while (items_to_send.size() != 0 || s_valid || levels_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin : src_accept
        in_xfer = aresetn && s_valid && (s_ready === 1'b1);
        if (in_xfer) begin
            mix_predict(s_data);
            items_in++;
        end
    end

    always @(negedge aclk) begin : src_drive
        if (aresetn && (!s_valid || in_xfer)) begin
            if (src_gap != 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (items_to_send.size() != 0) begin
                s_data <= items_to_send.pop_front();
                s_valid <= 1'b1;
                src_gap = no_idle ? 0 : gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : snk_drive
        if (aresetn) begin
            if (snk_stall != 0) begin
                snk_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    snk_stall = gap_len();
            end
        end
    end

    always @(posedge aclk) begin : lvl_monitor
        fvm_pkg::out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (levels_due.size() == 0) begin
                report_mismatch("unexpected level", int'(m_data), 0);
            end else begin
                want = levels_due.pop_front();
                if (m_data.level_high_byte !== want.level_high_byte)
                    report_mismatch("high byte", m_data.level_high_byte, want.level_high_byte);
                if (m_data.level_low_byte !== want.level_low_byte)
                    report_mismatch("low byte", m_data.level_low_byte, want.level_low_byte);
            end
            levels_checked++;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: shared base at the top of the store, wrap into word 0
        for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++)
            program_voice(v, 16'hFFFF, (v == 0) ? 16'hFFFF : (v == 1) ? 16'd3 : 16'd1);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_done++;
        push_tick();
        push_store(16'hFFFF, SAMPLE_MAX);
        push_store(16'h0000, SAMPLE_MIN);
        push_store(16'h0001, '0);
        push_store(16'h0002, SAMPLE_MIN);
        for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++)
            push_activate(v, 1'b1);
        gen_push(rand_item(FUNC_SPARE));
        repeat (4) push_tick();
        for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++)
            push_activate(v, 1'b1);
        push_store(16'hFFFF, SAMPLE_MIN);
        push_tick();
        push_activate(0, 1'b0);
        push_tick();
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            for (int v = 0; v < fvm_pkg::VOICE_COUNT; v++) begin
                if (p == 0)
                    program_voice(v, 16'hFFFF, 16'hFFFF);
                else if (p == 1)
                    program_voice(v, '0, (v % 2 == 0) ? 16'd0 : 16'hFFFF);
                else
                    program_voice(v, pick_base(), pick_len());
            end
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            settings_done++;
            no_idle = ($urandom_range(0, 3) == 0);
            gen_phase(ITEMS_PER_PHASE);
            wait_idle();
        end

        $display("tb: %0d input transfers, %0d levels checked, %0d voice settings",
                 items_in, levels_checked, settings_done);
        $display("tb: %0d mismatches in %0d cycles", err_count, cycle_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/fvm_pkg.sv
hdl/fvm_ram.sv
hdl/fvm_mix_out.sv
hdl/four_voice_pcm_sample_mixer_unit.sv
hdl/fvm_checker.sv
test/tb.sv
